// ===== rtl/core/vt4_pkg.sv =====
// Shared types and constants for the 4x4 vertex transform core.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package vt4_pkg;

   localparam int unsigned NumRegs       = 8;
   localparam int unsigned CsrIndexWidth = $clog2(NumRegs);
   localparam int unsigned CsrDataWidth  = 64;
   localparam int unsigned Dim           = 4;
   localparam int unsigned FracBits      = 16;

   typedef logic signed [31:0] q16_type;
   typedef q16_type [Dim-1:0] vec_type;
   typedef q16_type [Dim-1:0][Dim-1:0] matrix_type;

   // Full-precision product, a sum of two of them, and the packed words between stages.
   typedef logic signed [63:0] prod_type;
   typedef logic signed [64:0] pair_type;
   typedef prod_type [Dim-1:0][Dim-1:0] prod_mat_type;
   typedef pair_type [Dim-1:0][1:0] pair_mat_type;

   typedef struct packed {
      vec_type comp;
      logic    saturated;
   } result_type;

   typedef logic [CsrDataWidth-1:0] csr_word_type;
   typedef csr_word_type [NumRegs-1:0] csr_file_type;

   // Reset contents form the identity matrix (1.0 is 0x0001_0000 in Q16.16).
   localparam csr_file_type CsrReset = '{
      64'h0001_0000_0000_0000,  // row 3, columns 2 and 3
      64'h0000_0000_0000_0000,  // row 3, columns 0 and 1
      64'h0000_0000_0001_0000,  // row 2, columns 2 and 3
      64'h0000_0000_0000_0000,  // row 2, columns 0 and 1
      64'h0000_0000_0000_0000,  // row 1, columns 2 and 3
      64'h0001_0000_0000_0000,  // row 1, columns 0 and 1
      64'h0000_0000_0000_0000,  // row 0, columns 2 and 3
      64'h0000_0000_0001_0000   // row 0, columns 0 and 1
   };

endpackage

// ===== rtl/core/vt4_ifs.sv =====
// Stream interfaces for the vertex transform core: vertex words in, result words out.
// Depends on vt4_pkg for the Q16.16 component type.
interface vt4_req_if;
   logic            valid;
   logic            ready;
   vt4_pkg::q16_type x_in;
   vt4_pkg::q16_type y_in;
   vt4_pkg::q16_type z_in;
   vt4_pkg::q16_type w_in;

   modport source (output valid, output x_in, output y_in, output z_in, output w_in,
                   input ready);
   modport sink   (input valid, input x_in, input y_in, input z_in, input w_in,
                   output ready);
endinterface

interface vt4_rsp_if;
   logic             valid;
   logic             ready;
   vt4_pkg::q16_type x_out;
   vt4_pkg::q16_type y_out;
   vt4_pkg::q16_type z_out;
   vt4_pkg::q16_type w_out;
   logic             saturated;

   modport source (output valid, output x_out, output y_out, output z_out, output w_out,
                   output saturated, input ready);
   modport sink   (input valid, input x_out, input y_out, input z_out, input w_out,
                   input saturated, output ready);
endinterface

// ===== rtl/core/vt4_mul_stage.sv =====
// First pipeline stage: sixteen 32x32 signed multiplies, products registered.
// Depends on vt4_pkg.
module vt4_mul_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vt4_pkg::vec_type      in_vec,
   input  vt4_pkg::matrix_type   matrix,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vt4_pkg::prod_mat_type out_prod
);

   logic                  valid_ff;
   vt4_pkg::prod_mat_type prod_ff;
   vt4_pkg::prod_mat_type prod_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int r = 0; r < vt4_pkg::Dim; r++) begin
         for (int c = 0; c < vt4_pkg::Dim; c++) begin
            prod_in[r][c] = $signed(matrix[r][c]) * $signed(in_vec[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

endmodule

// ===== rtl/core/vt4_pair_stage.sv =====
// Second pipeline stage: adds the products of each row in pairs, at full precision.
// Depends on vt4_pkg.
module vt4_pair_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vt4_pkg::prod_mat_type in_prod,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vt4_pkg::pair_mat_type out_pair
);

   logic                  valid_ff;
   vt4_pkg::pair_mat_type pair_ff;
   vt4_pkg::pair_mat_type pair_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int r = 0; r < vt4_pkg::Dim; r++) begin
         for (int h = 0; h < 2; h++) begin
            pair_in[r][h] = vt4_pkg::pair_type'($signed(in_prod[r][2*h]))
                          + vt4_pkg::pair_type'($signed(in_prod[r][2*h+1]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pair_ff <= pair_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pair  = pair_ff;

endmodule

// ===== rtl/core/vt4_sat_stage.sv =====
// Last pipeline stage: final row sum, arithmetic shift by 16 and saturation to 32 bits.
// Its register is the result register seen on the output channel. Depends on vt4_pkg.
module vt4_sat_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vt4_pkg::pair_mat_type in_pair,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vt4_pkg::result_type   out_result
);

   logic                valid_ff;
   vt4_pkg::result_type result_ff;
   vt4_pkg::result_type result_in;
   logic signed [65:0]  row_sum [vt4_pkg::Dim];
   logic [65:47]        top_bits [vt4_pkg::Dim];
   logic [vt4_pkg::Dim-1:0] clamp;

   assign in_ready = !valid_ff || out_ready;

   // The shifted value is row_sum[65:16]; it fits in 32 bits when bits 65 down to 47 agree.
   always_comb begin
      for (int r = 0; r < vt4_pkg::Dim; r++) begin
         row_sum[r]  = 66'($signed(in_pair[r][0])) + 66'($signed(in_pair[r][1]));
         top_bits[r] = row_sum[r][65:47];
         clamp[r]    = !((&top_bits[r]) || !(|top_bits[r]));
         if (!clamp[r]) begin
            result_in.comp[r] = row_sum[r][47:vt4_pkg::FracBits];
         end else if (row_sum[r][65]) begin
            result_in.comp[r] = 32'sh8000_0000;
         end else begin
            result_in.comp[r] = 32'sh7FFF_FFFF;
         end
      end
      result_in.saturated = |clamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/core/vertex_transform_4x4_core.sv =====
// Top level of the 4x4 vertex transform core: matrix registers and three pipeline stages.
// Depends on vt4_pkg, vt4_ifs, vt4_mul_stage, vt4_pair_stage and vt4_sat_stage.
//
// This core multiplies each homogeneous vertex word (x, y, z, w, signed Q16.16) by a 4x4
// matrix held in eight 64-bit registers, two Q16.16 entries per register (even column in
// bits 31:0, odd column in bits 63:32), and returns one result word per vertex. Each output
// component is the exact sum of four 64-bit products, shifted right by 16 with rounding
// toward minus infinity, then clamped to the signed 32-bit range; the saturated bit is set
// when any component was clamped. After reset the matrix is the identity. A vertex can be
// accepted every clock cycle while the result side is not stalled. Each result passes in
// order through the registers of the sixteen multipliers, of the pairwise adds, and of
// the final add and saturation, whose register drives the result channel. With rsp_bus.ready
// held high req_bus.ready is always high; result-side stalls pass back combinationally
// through the full stages, so empty stages still take new vertices.
// Registers are written through csr_we, csr_index and csr_wdata and should only be written
// while no vertex is in flight.
module vertex_transform_4x4_core (
   input  logic                                  clock,
   input  logic                                  reset,
   vt4_req_if.sink                               req_bus,
   vt4_rsp_if.source                             rsp_bus,
   input  logic                                  csr_we,
   input  logic [vt4_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [vt4_pkg::CsrDataWidth-1:0]      csr_wdata
);

   vt4_pkg::csr_file_type csr_ff;
   vt4_pkg::matrix_type   matrix;
   vt4_pkg::vec_type      req_vec;

   logic                  mul_valid;
   logic                  mul_ready;
   vt4_pkg::prod_mat_type mul_prod;
   logic                  pair_valid;
   logic                  pair_ready;
   vt4_pkg::pair_mat_type pair_sum;
   vt4_pkg::result_type   result;

   // Matrix registers. The index covers exactly the eight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= vt4_pkg::CsrReset;
      end else if (csr_we) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   // Unpack the registers into matrix entries: row r, column c lives in register 2r + c/2.
   for (genvar r = 0; r < vt4_pkg::Dim; r++) begin : g_row
      for (genvar c = 0; c < vt4_pkg::Dim; c++) begin : g_col
         if (c % 2 == 1) begin : g_odd
            assign matrix[r][c] = csr_ff[(2*r) + (c/2)][63:32];
         end else begin : g_even
            assign matrix[r][c] = csr_ff[(2*r) + (c/2)][31:0];
         end
      end
   end

   assign req_vec[0] = req_bus.x_in;
   assign req_vec[1] = req_bus.y_in;
   assign req_vec[2] = req_bus.z_in;
   assign req_vec[3] = req_bus.w_in;

   vt4_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_vec    (req_vec),
      .matrix    (matrix),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_prod  (mul_prod)
   );

   vt4_pair_stage u_pair (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_prod   (mul_prod),
      .out_valid (pair_valid),
      .out_ready (pair_ready),
      .out_pair  (pair_sum)
   );

   vt4_sat_stage u_sat (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pair_valid),
      .in_ready   (pair_ready),
      .in_pair    (pair_sum),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_result (result)
   );

   assign rsp_bus.x_out     = result.comp[0];
   assign rsp_bus.y_out     = result.comp[1];
   assign rsp_bus.z_out     = result.comp[2];
   assign rsp_bus.w_out     = result.comp[3];
   assign rsp_bus.saturated = result.saturated;

endmodule

// ===== rtl/core/vt4_checker.sv =====
// Port-level checker for the vertex transform core, with the bind that attaches it.
// Depends on vt4_pkg and on the port list of vertex_transform_4x4_core.
module vt4_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vt4_pkg::q16_type x_out,
   input vt4_pkg::q16_type y_out,
   input vt4_pkg::q16_type z_out,
   input vt4_pkg::q16_type w_out,
   input logic             saturated
);

   logic [31:0] pos_max;
   logic [31:0] neg_max;

   assign pos_max = 32'h7FFF_FFFF;
   assign neg_max = 32'h8000_0000;

   // A result word that waits must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({x_out, y_out, z_out, w_out, saturated}))
      else $error("result word changed while stalled");

   // With the result side open, the input side must be open too.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is ready");

   // An accepted vertex shows up as a valid result when the output side does not stall in between.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing three cycles after accept");

   // A clamped result must show at least one component at a limit.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |->
         x_out == pos_max || x_out == neg_max || y_out == pos_max || y_out == neg_max ||
         z_out == pos_max || z_out == neg_max || w_out == pos_max || w_out == neg_max)
      else $error("saturated set with no component at a limit");

   // Pipeline is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind vertex_transform_4x4_core vt4_checker u_vt4_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .x_out     (rsp_bus.x_out),
   .y_out     (rsp_bus.y_out),
   .z_out     (rsp_bus.z_out),
   .w_out     (rsp_bus.w_out),
   .saturated (rsp_bus.saturated)
);

// ===== sim/vt4_result_checker.sv =====
// Result checker for the 4x4 vertex transform core: predicts every result word and compares.
// Depends on vt4_pkg and vt4_ifs; watches both streams and the register write port.
module vt4_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   vt4_req_if                                req_bus,
   vt4_rsp_if                                rsp_bus,
   input  logic                              csr_we,
   input  logic [vt4_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [vt4_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import vt4_pkg::*;

   localparam int unsigned RegRow0Cols01 = 0;
   localparam int unsigned RegRow1Cols01 = 2;
   localparam int unsigned RegRow2Cols23 = 5;
   localparam int unsigned RegRow3Cols23 = 7;
   localparam int unsigned ReportLimit   = 10;

   localparam logic signed [65:0] SatHigh = 66'sd2147483647;
   localparam logic signed [65:0] SatLow  = -66'sd2147483648;

   csr_file_type matrix_regs;
   result_type   expected_results[$];
   int           result_index;

   function automatic q16_type matrix_entry(input csr_file_type regs, input int row,
                                            input int col);
      return regs[2 * row + col / 2][32 * (col % 2) +: 32];
   endfunction

   // Each row is summed exactly, floored by the shift, then clamped to 32 bits.
   function automatic result_type transform_vertex(input csr_file_type regs,
                                                   input vec_type vertex);
      result_type              res;
      logic signed [65:0]      acc;
      logic signed [65:0]      scaled;
      longint                  product;
      res.saturated = 1'b0;
      for (int row = 0; row < Dim; row++) begin
         acc = '0;
         for (int col = 0; col < Dim; col++) begin
            product = longint'(matrix_entry(regs, row, col)) * longint'(vertex[col]);
            acc += product;
         end
         scaled = acc >>> FracBits;
         if (scaled > SatHigh) begin
            res.comp[row] = 32'sh7FFF_FFFF;
            res.saturated = 1'b1;
         end else if (scaled < SatLow) begin
            res.comp[row] = 32'sh8000_0000;
            res.saturated = 1'b1;
         end else begin
            res.comp[row] = scaled[31:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      vec_type    vertex;
      result_type got;
      result_type want;
      if (reset) begin
         matrix_regs                = '0;
         matrix_regs[RegRow0Cols01] = 64'h0000_0000_0001_0000;
         matrix_regs[RegRow1Cols01] = 64'h0001_0000_0000_0000;
         matrix_regs[RegRow2Cols23] = 64'h0000_0000_0001_0000;
         matrix_regs[RegRow3Cols23] = 64'h0001_0000_0000_0000;
         expected_results.delete();
         fail_count   = 0;
         pending      = 0;
         result_index = 0;
      end else begin
         if (csr_we)
            matrix_regs[csr_index] = csr_wdata;
         if (req_bus.valid && req_bus.ready) begin
            vertex[0] = req_bus.x_in;
            vertex[1] = req_bus.y_in;
            vertex[2] = req_bus.z_in;
            vertex[3] = req_bus.w_in;
            expected_results.push_back(transform_vertex(matrix_regs, vertex));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.comp[0]   = rsp_bus.x_out;
            got.comp[1]   = rsp_bus.y_out;
            got.comp[2]   = rsp_bus.z_out;
            got.comp[3]   = rsp_bus.w_out;
            got.saturated = rsp_bus.saturated;
            if (expected_results.size() == 0) begin
               if (fail_count < ReportLimit)
                  $display("result word %0d arrived with nothing outstanding", result_index);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (fail_count < ReportLimit)
                     $display("word %0d: exp %h %h %h %h sat %b, got %h %h %h %h sat %b",
                              result_index,
                              want.comp[0], want.comp[1], want.comp[2], want.comp[3],
                              want.saturated, got.comp[0], got.comp[1], got.comp[2],
                              got.comp[3], got.saturated);
                  fail_count++;
               end
            end
            result_index++;
         end
         pending = expected_results.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Top of the 4x4 vertex transform testbench: clock, reset, stimulus and the final verdict.
// Depends on vt4_pkg, vt4_ifs, the core and vt4_result_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vt4_pkg::*;

   localparam real         PeriodNs     = 12.0;
   localparam int unsigned ResetCycles  = 4;
   localparam int unsigned RandomPhases = 12;
   localparam int unsigned RandomItems  = 1740;
   localparam int unsigned QuietPhase   = 5;
   localparam int unsigned SettleCycles = 10;
   localparam int unsigned StallPercent = 33;
   // The limit lies far above the length of the slowest legal run.
   localparam int unsigned CycleLimit   = 150000;

   localparam q16_type MaxQ   = 32'sh7FFF_FFFF;
   localparam q16_type MinQ   = 32'sh8000_0000;
   localparam q16_type OneQ   = 32'sh0001_0000;
   localparam q16_type HalfQ  = 32'sh0000_8000;
   localparam q16_type AllOne = 32'shFFFF_FFFF;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   csr_word_type             csr_wdata;
   bit                       stall_enable;
   int                       fail_count;
   int                       pending;
   int unsigned              cycle_count = 0;

   vt4_req_if req_bus ();
   vt4_rsp_if rsp_bus ();

   vertex_transform_4x4_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vt4_result_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #(PeriodNs / 2.0) clock = ~clock;
   end

   // The result side stalls at random while stalling is enabled, and never otherwise.
   // Every input of the core is changed only here or in the stimulus block, always at
   // the rising edge, so the checker sees stable values on both sides of each edge.
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= !stall_enable || ($urandom_range(0, 99) >= StallPercent);
   end

   // A hung handshake or a lost result ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("vertex_transform_4x4_core: mismatch");
         $finish;
      end
   end

   // Mostly small magnitudes (within four units) keep the sums in range so that the
   // arithmetic itself is checked; the rest are the extremes, zero, all ones and fully random patterns,
   // which drive the saturation paths and give every bit both values.
   function automatic q16_type random_q16(input bit mostly_small);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (mostly_small && pick < 8)
         return q16_type'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      case ($urandom_range(0, 5))
         0:       return MaxQ;
         1:       return MinQ;
         2:       return '0;
         3:       return AllOne;
         default: return q16_type'($urandom);
      endcase
   endfunction

   // Presents one vertex word and returns at the edge where it is taken. The sender
   // idles at random in front of each word while stalling is enabled.
   task automatic send_vertex(input q16_type x, input q16_type y, input q16_type z,
                              input q16_type w);
      while (stall_enable && $urandom_range(0, 99) < StallPercent) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.x_in  <= x;
      req_bus.y_in  <= y;
      req_bus.z_in  <= z;
      req_bus.w_in  <= w;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // Holds the sender off until every expected result word has come back. The first
   // edge is always taken so that the checker has counted the last accepted vertex.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending != 0);
   endtask

   // Matrix writes only happen with the pipeline empty; each register packs the even
   // column of a row in its low half and the odd column in its high half.
   task automatic load_matrix(input matrix_type m);
      wait_for_drain();
      for (int row = 0; row < Dim; row++) begin
         for (int half = 0; half < 2; half++) begin
            csr_we    <= 1'b1;
            csr_index <= CsrIndexWidth'(2 * row + half);
            csr_wdata <= {m[row][2 * half + 1], m[row][2 * half]};
            @(posedge clock);
         end
      end
      csr_we <= 1'b0;
   endtask

   function automatic matrix_type uniform_matrix(input q16_type value);
      matrix_type m;
      for (int row = 0; row < Dim; row++)
         for (int col = 0; col < Dim; col++)
            m[row][col] = value;
      return m;
   endfunction

   initial begin
      matrix_type m;
      bit         small_matrix;
      reset         = 1'b1;
      stall_enable  = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.x_in  = '0;
      req_bus.y_in  = '0;
      req_bus.z_in  = '0;
      req_bus.w_in  = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset the matrix must be the identity, so each output equals
      // its input. A word with both x and w nonzero shows that the w row takes its own
      // diagonal entry and nothing from column 0 or column 2.
      send_vertex('0, '0, '0, '0);
      send_vertex(MaxQ, MaxQ, MaxQ, MaxQ);
      send_vertex(MinQ, MinQ, MinQ, MinQ);
      send_vertex(OneQ, -OneQ, 32'sh0000_0001, AllOne);
      send_vertex(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
      send_vertex(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);

      // Half-scale diagonal and one negative step at row 3, column 2: odd negative inputs show
      // that the shift floors toward minus infinity instead of truncating toward zero.
      m = uniform_matrix('0);
      for (int d = 0; d < Dim; d++)
         m[d][d] = HalfQ;
      m[3][2] = AllOne;
      load_matrix(m);
      send_vertex(AllOne, 32'sh0000_0001, -32'sh0000_0003, MaxQ);
      send_vertex(MinQ, MaxQ, 32'sh0001_8000, -32'sh0001_8000);

      // Largest positive entries everywhere: clamping in both directions, and
      // large products that cancel without clamping.
      load_matrix(uniform_matrix(MaxQ));
      send_vertex(MaxQ, MaxQ, MaxQ, MaxQ);
      send_vertex(MinQ, MinQ, MinQ, MinQ);
      send_vertex(MaxQ, MinQ, MaxQ, MinQ);
      send_vertex('0, '0, '0, 32'sh0000_0001);

      // Most negative entries: the all-negative product sum is the largest one possible.
      load_matrix(uniform_matrix(MinQ));
      send_vertex(MinQ, MinQ, MinQ, MinQ);
      send_vertex(32'sh0000_0001, '0, '0, '0);
      send_vertex(MaxQ, '0, '0, '0);

      load_matrix(uniform_matrix('0));
      send_vertex(MaxQ, MinQ, MaxQ, MinQ);

      // Every entry one negative step: small negative sums that must floor.
      load_matrix(uniform_matrix(AllOne));
      send_vertex(MaxQ, MaxQ, MaxQ, MaxQ);
      send_vertex(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);

      // Random matrices with random vertex streams. One phase runs with no idling on
      // either side, so the pipeline is exercised at full rate for a long stretch.
      for (int phase = 0; phase < RandomPhases; phase++) begin
         small_matrix = $urandom_range(0, 9) < 6;
         for (int row = 0; row < Dim; row++)
            for (int col = 0; col < Dim; col++)
               m[row][col] = random_q16(small_matrix);
         load_matrix(m);
         stall_enable = (phase != QuietPhase);
         for (int i = 0; i < RandomItems / RandomPhases; i++) begin
            small_matrix = $urandom_range(0, 1);
            send_vertex(random_q16(small_matrix), random_q16(small_matrix),
                        random_q16(small_matrix), random_q16(small_matrix));
         end
      end

      wait_for_drain();
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("vertex_transform_4x4_core: match");
      else
         $display("vertex_transform_4x4_core: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/vt4_pkg.sv
rtl/core/vt4_ifs.sv
rtl/core/vt4_mul_stage.sv
rtl/core/vt4_pair_stage.sv
rtl/core/vt4_sat_stage.sv
rtl/core/vertex_transform_4x4_core.sv
rtl/core/vt4_checker.sv
sim/vt4_result_checker.sv
sim/tb_top.sv
